### hw/rtl/size_class_page_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_CLASS_PAGE_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_PAGE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scpa_pkg.sv
package scpa_pkg;

    localparam int NUM_PAGES_DEF    = 16;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 20;
    localparam int NUM_CLASSES_DEF  = 8;

    localparam int ADDR_W      = 16;
    localparam int OBJ_W       = 11;
    localparam int CLS_W       = 3;
    localparam int NUM_CLS_MAX = 8;
    localparam int MAX_OBJECT  = 1024;
    localparam int MIN_SHIFT   = 3;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERSIZED = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

endpackage

### hw/rtl/scpa_req_if.sv
interface scpa_req_if;
    import scpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output request_size, output address,
                    input ready);
    modport sink (input valid, input op, input request_size, input address,
                  output ready);
endinterface

### hw/rtl/scpa_res_if.sv
interface scpa_res_if;
    import scpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_address;
    logic [OBJ_W-1:0]  object_size;
    logic [1:0]        status;

    modport source (output valid, output granted_address, output object_size,
                    output status, input ready);
    modport sink (input valid, input granted_address, input object_size,
                  input status, output ready);
endinterface

### hw/rtl/scpa_ram.sv
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/size_class_page_allocator.sv
// Channel   Dir  Payload                                   Moves on
// i_req     in   op, request_size, address                 valid & ready
// o_res     out  granted_address, object_size, status      valid & ready
//
// One request is worked at a time; the next is taken only once the result of the last
// has gone to the output register. The time a request takes is set by the
// single-port page record memory, which every list link update reads and writes
// back in turn, and by the slot link memory read of a reused slot.
// Reset is synchronous and active low; it clears the page live bits and the
// list heads, and the memories need no clearing pass.
// A finished result waits in the output register while the next request is taken;
// the one after that waits in its last step until the register has drained.
`include "size_class_page_allocator_defines.svh"

module size_class_page_allocator #(
    parameter int NUM_PAGES    = scpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES   = scpa_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = scpa_pkg::HEADER_BYTES_DEF,
    parameter int NUM_CLASSES  = scpa_pkg::NUM_CLASSES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scpa_req_if.sink  i_req,
    scpa_res_if.source o_res
);
    import scpa_pkg::*;

    localparam int PAGE_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LINK_W    = PAGE_W + 1;
    localparam int SLOTS_MAX = (PAGE_BYTES - HEADER_BYTES) / 8;
    localparam int SLOT_W    = $clog2(SLOTS_MAX + 1);
    localparam int MAX_PQ    = 65535 / PAGE_BYTES;
    localparam int PQ_W      = 8;
    localparam int LNK_DEPTH = NUM_PAGES << SLOT_W;
    localparam int LNK_AW    = PAGE_W + SLOT_W;

    localparam logic [LINK_W-1:0] LINK_NIL = {LINK_W{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_AREC = 4'd3;
    localparam logic [3:0] S_AOP  = 4'd4;
    localparam logic [3:0] S_ALNK = 4'd5;
    localparam logic [3:0] S_FREC = 4'd6;
    localparam logic [3:0] S_QREC = 4'd7;
    localparam logic [3:0] S_SEQ  = 4'd8;
    localparam logic [3:0] S_REM  = 4'd9;
    localparam logic [3:0] S_REM2 = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;
    localparam logic [3:0] S_NBRD = 4'd12;
    localparam logic [3:0] S_NBWR = 4'd13;
    localparam logic [3:0] S_WB   = 4'd14;
    localparam logic [3:0] S_RES  = 4'd15;

    localparam logic LIST_OPEN = 1'b0;
    localparam logic LIST_FULL = 1'b1;
    localparam logic FLD_PREV  = 1'b0;
    localparam logic FLD_NEXT  = 1'b1;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] cnt;
        logic [SLOT_W-1:0] fhead;
        logic [SLOT_W-1:0] bump;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    function automatic logic [SLOT_W-1:0] slots_of(input logic [CLS_W-1:0] c);
        slots_of = SLOT_W'((PAGE_BYTES - HEADER_BYTES) >> (c + MIN_SHIFT));
    endfunction

    function automatic logic [OBJ_W-1:0] size_of(input logic [CLS_W-1:0] c);
        size_of = OBJ_W'(11'd8 << c);
    endfunction

    logic [3:0]        r_state;
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [PQ_W-1:0]   r_pq;
    logic              r_pgok;
    logic [CLS_W-1:0]  r_cls;
    logic              r_over;
    logic [PAGE_W-1:0] r_page;
    logic [ADDR_W-1:0] r_off;
    t_rec              r_rec;
    logic [SLOT_W-1:0] r_slot;
    logic [1:0]        r_phase;
    logic              r_lsel;
    logic [PAGE_W-1:0] r_nb;
    logic              r_nb_fld;
    logic [LINK_W-1:0] r_nb_val;
    logic              r_nb_rem2;
    logic [NUM_PAGES-1:0] r_live;
    logic [LINK_W-1:0] r_open [NUM_CLS_MAX];
    logic [LINK_W-1:0] r_full [NUM_CLS_MAX];
    logic [ADDR_W-1:0] r_res_addr;
    logic [OBJ_W-1:0]  r_res_obj;
    logic [1:0]        r_res_st;
    logic              r_ov;
    logic [ADDR_W-1:0] r_o_addr;
    logic [OBJ_W-1:0]  r_o_obj;
    logic [1:0]        r_o_st;

    // Address and size decode and free page search, from the registered request.
    logic [MAX_PQ:0]   ge_vec;
    logic [PQ_W-1:0]   pq_cnt;
    logic [7:0]        cls_vec;
    logic [3:0]        cnum;
    logic [ADDR_W-1:0] off_c;
    logic [PAGE_W-1:0] pf;
    logic              pf_found;
    logic              live_ok;

    always_comb begin
        ge_vec[0] = 1'b0;
        for (int k = 1; k <= MAX_PQ; k++) begin
            ge_vec[k] = (32'(r_addr) >= 32'(k * PAGE_BYTES));
        end
        pq_cnt = PQ_W'($countones(ge_vec));
        for (int c = 0; c < 8; c++) begin
            cls_vec[c] = (32'(8 << c) < 32'(r_size));
        end
        cnum  = 4'($countones(cls_vec));
        off_c = ADDR_W'(32'(r_addr) - 32'(r_pq) * PAGE_BYTES);
        pf       = '0;
        pf_found = 1'b0;
        for (int k = NUM_PAGES - 1; k >= 0; k--) begin
            if (!r_live[k]) begin
                pf       = PAGE_W'(k);
                pf_found = 1'b1;
            end
        end
        live_ok = r_pgok && r_live[r_page];
    end

    // Memories.
    logic [PAGE_W-1:0] rec_addr;
    logic              rec_we;
    t_rec              rec_wdata;
    logic [REC_W-1:0]  rec_rraw;
    t_rec              rec_rdata;
    logic [LNK_AW-1:0] lnk_addr;
    logic              lnk_we;
    logic [SLOT_W-1:0] lnk_wdata;
    logic [SLOT_W-1:0] lnk_rdata;

    assign rec_rdata = t_rec'(rec_rraw);

    logic [LINK_W-1:0] head_cur;
    logic [SLOT_W-1:0] allocated;
    logic [ADDR_W-1:0] rel_off;
    logic [ADDR_W-1:0] slot_f;
    logic [ADDR_W-1:0] gaddr;

    always_comb begin
        head_cur  = (r_lsel == LIST_FULL) ? r_full[r_cls] : r_open[r_cls];
        allocated = slots_of(r_cls) - r_rec.cnt;
        rel_off   = r_off - ADDR_W'(HEADER_BYTES);
        slot_f    = rel_off >> (rec_rdata.cls + MIN_SHIFT);
        gaddr     = ADDR_W'(32'(r_page) * PAGE_BYTES + HEADER_BYTES
                    + (32'(r_slot) << (r_cls + MIN_SHIFT)));
    end

    always_comb begin
        rec_addr  = r_page;
        rec_we    = 1'b0;
        rec_wdata = r_rec;
        lnk_addr  = {r_page, r_rec.fhead};
        lnk_we    = 1'b0;
        lnk_wdata = r_rec.fhead;
        case (r_state)
            S_DEC: begin
                if (r_op == OP_ALLOC) begin
                    rec_addr = r_open[r_cls][PAGE_W-1:0];
                end
            end
            S_NBRD: begin
                rec_addr = r_nb;
            end
            S_NBWR: begin
                rec_addr  = r_nb;
                rec_we    = 1'b1;
                rec_wdata = rec_rdata;
                if (r_nb_fld == FLD_NEXT) begin
                    rec_wdata.next = r_nb_val;
                end else begin
                    rec_wdata.prev = r_nb_val;
                end
            end
            S_SEQ: begin
                // The freed slot is threaded onto the page's free list, unless the page becomes empty.
                if (r_op == OP_FREE && r_phase == 2'd2
                    && ({1'b0, r_rec.cnt} + 1'b1) < {1'b0, slots_of(r_cls)}) begin
                    lnk_addr = {r_page, r_slot};
                    lnk_we   = 1'b1;
                end
            end
            S_WB: begin
                rec_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    scpa_ram #(.WIDTH(REC_W), .DEPTH(NUM_PAGES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_addr  (rec_addr),
        .i_wdata (REC_W'(rec_wdata)),
        .o_rdata (rec_rraw)
    );

    scpa_ram #(.WIDTH(SLOT_W), .DEPTH(LNK_DEPTH)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_addr  (lnk_addr),
        .i_wdata (lnk_wdata),
        .o_rdata (lnk_rdata)
    );

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_ov;
    assign o_res.granted_address = r_o_addr;
    assign o_res.object_size     = r_o_obj;
    assign o_res.status          = r_o_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_live  <= '0;
            for (int i = 0; i < NUM_CLS_MAX; i++) begin
                r_open[i] <= LINK_NIL;
                r_full[i] <= LINK_NIL;
            end
        end else begin
            if (r_ov && o_res.ready && r_state != S_RES) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.op;
                        r_size  <= i_req.request_size;
                        r_addr  <= i_req.address;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_pq    <= pq_cnt;
                    r_pgok  <= (32'(pq_cnt) < NUM_PAGES);
                    r_page  <= PAGE_W'(pq_cnt);
                    r_cls   <= CLS_W'(cnum);
                    r_over  <= (32'(r_size) > MAX_OBJECT) || (32'(cnum) >= NUM_CLASSES);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_off      <= off_c;
                    r_res_addr <= '0;
                    r_phase    <= 2'd0;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_over) begin
                                r_res_obj <= '0;
                                r_res_st  <= ST_OVERSIZED;
                                r_state   <= S_RES;
                            end else begin
                                r_res_obj <= size_of(r_cls);
                                if (r_open[r_cls] != LINK_NIL) begin
                                    r_res_st <= ST_OK;
                                    r_page   <= r_open[r_cls][PAGE_W-1:0];
                                    r_state  <= S_AREC;
                                end else if (!pf_found) begin
                                    r_res_st <= ST_EXHAUSTED;
                                    r_state  <= S_RES;
                                end else begin
                                    // Claimed page goes straight into an empty open list.
                                    r_res_st     <= ST_OK;
                                    r_page       <= pf;
                                    r_live[pf]   <= 1'b1;
                                    r_rec.cls    <= r_cls;
                                    r_rec.cnt    <= slots_of(r_cls);
                                    r_rec.fhead  <= '0;
                                    r_rec.bump   <= '0;
                                    r_rec.prev   <= LINK_NIL;
                                    r_rec.next   <= LINK_NIL;
                                    r_open[r_cls] <= {1'b0, pf};
                                    r_state      <= S_AOP;
                                end
                            end
                        end
                        OP_FREE: begin
                            r_res_obj <= '0;
                            if (!live_ok || 32'(off_c) < HEADER_BYTES) begin
                                r_res_st <= ST_BAD_ADDR;
                                r_state  <= S_RES;
                            end else begin
                                r_res_st <= ST_OK;
                                r_state  <= S_FREC;
                            end
                        end
                        OP_QUERY: begin
                            r_res_obj <= '0;
                            if (!live_ok) begin
                                r_res_st <= ST_BAD_ADDR;
                                r_state  <= S_RES;
                            end else begin
                                r_res_st <= ST_OK;
                                r_state  <= S_QREC;
                            end
                        end
                        default: begin
                            r_res_obj <= '0;
                            r_res_st  <= ST_OK;
                            r_state   <= S_RES;
                        end
                    endcase
                end
                S_AREC: begin
                    r_rec   <= rec_rdata;
                    r_state <= S_AOP;
                end
                S_AOP: begin
                    r_rec.cnt <= r_rec.cnt - 1'b1;
                    if (r_rec.bump > allocated) begin
                        r_slot  <= r_rec.fhead;
                        r_state <= S_ALNK;
                    end else begin
                        r_slot     <= r_rec.bump;
                        r_rec.bump <= r_rec.bump + 1'b1;
                        r_state    <= S_SEQ;
                    end
                end
                S_ALNK: begin
                    r_rec.fhead <= lnk_rdata;
                    r_state     <= S_SEQ;
                end
                S_FREC: begin
                    r_rec <= rec_rdata;
                    r_cls <= rec_rdata.cls;
                    if (slot_f >= ADDR_W'(slots_of(rec_rdata.cls))) begin
                        r_res_st <= ST_BAD_ADDR;
                        r_state  <= S_RES;
                    end else begin
                        r_slot    <= SLOT_W'(slot_f);
                        r_res_obj <= size_of(rec_rdata.cls);
                        r_state   <= S_SEQ;
                    end
                end
                S_QREC: begin
                    r_res_obj <= size_of(rec_rdata.cls);
                    r_state   <= S_RES;
                end
                S_SEQ: begin
                    if (r_op == OP_ALLOC) begin
                        case (r_phase)
                            2'd0: begin
                                if (r_rec.cnt == '0) begin
                                    r_lsel  <= LIST_OPEN;
                                    r_phase <= 2'd1;
                                    r_state <= S_REM;
                                end else begin
                                    r_state <= S_WB;
                                end
                            end
                            2'd1: begin
                                r_lsel  <= LIST_FULL;
                                r_phase <= 2'd2;
                                r_state <= S_PUSH;
                            end
                            default: begin
                                r_state <= S_WB;
                            end
                        endcase
                    end else begin
                        case (r_phase)
                            2'd0: begin
                                // A full page reopens before the count goes up.
                                if (r_rec.cnt == '0) begin
                                    r_lsel  <= LIST_FULL;
                                    r_phase <= 2'd1;
                                    r_state <= S_REM;
                                end else begin
                                    r_phase <= 2'd2;
                                end
                            end
                            2'd1: begin
                                r_lsel  <= LIST_OPEN;
                                r_phase <= 2'd2;
                                r_state <= S_PUSH;
                            end
                            2'd2: begin
                                if (({1'b0, r_rec.cnt} + 1'b1) >= {1'b0, slots_of(r_cls)}) begin
                                    r_lsel         <= LIST_OPEN;
                                    r_phase        <= 2'd3;
                                    r_live[r_page] <= 1'b0;
                                    r_state        <= S_REM;
                                end else begin
                                    r_rec.fhead <= r_slot;
                                    r_rec.cnt   <= r_rec.cnt + 1'b1;
                                    r_state     <= S_WB;
                                end
                            end
                            default: begin
                                r_state <= S_RES;
                            end
                        endcase
                    end
                end
                S_REM: begin
                    if (r_rec.prev == LINK_NIL) begin
                        if (r_lsel == LIST_FULL) begin
                            r_full[r_cls] <= r_rec.next;
                        end else begin
                            r_open[r_cls] <= r_rec.next;
                        end
                        r_state <= S_REM2;
                    end else begin
                        r_nb      <= r_rec.prev[PAGE_W-1:0];
                        r_nb_fld  <= FLD_NEXT;
                        r_nb_val  <= r_rec.next;
                        r_nb_rem2 <= 1'b1;
                        r_state   <= S_NBRD;
                    end
                end
                S_REM2: begin
                    if (r_rec.next != LINK_NIL) begin
                        r_nb      <= r_rec.next[PAGE_W-1:0];
                        r_nb_fld  <= FLD_PREV;
                        r_nb_val  <= r_rec.prev;
                        r_nb_rem2 <= 1'b0;
                        r_state   <= S_NBRD;
                    end else begin
                        r_state <= S_SEQ;
                    end
                end
                S_PUSH: begin
                    r_rec.next <= head_cur;
                    r_rec.prev <= LINK_NIL;
                    if (r_lsel == LIST_FULL) begin
                        r_full[r_cls] <= {1'b0, r_page};
                    end else begin
                        r_open[r_cls] <= {1'b0, r_page};
                    end
                    if (head_cur != LINK_NIL) begin
                        r_nb      <= head_cur[PAGE_W-1:0];
                        r_nb_fld  <= FLD_PREV;
                        r_nb_val  <= {1'b0, r_page};
                        r_nb_rem2 <= 1'b0;
                        r_state   <= S_NBRD;
                    end else begin
                        r_state <= S_SEQ;
                    end
                end
                S_NBRD: begin
                    r_state <= S_NBWR;
                end
                S_NBWR: begin
                    r_state <= r_nb_rem2 ? S_REM2 : S_SEQ;
                end
                S_WB: begin
                    if (r_op == OP_ALLOC) begin
                        r_res_addr <= gaddr;
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov     <= 1'b1;
                        r_o_addr <= r_res_addr;
                        r_o_obj  <= r_res_obj;
                        r_o_st   <= r_res_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SCPA_ASSERT_NXT(a_accept_decodes, i_req.valid && i_req.ready, r_state == S_PRE, "accepted request did not start decoding")
    `SCPA_ASSERT_IMP(a_oversize_empty, o_res.valid && o_res.status == ST_OVERSIZED, o_res.granted_address == '0 && o_res.object_size == '0, "oversized result carries data")
    `SCPA_ASSERT_IMP(a_rec_write_state, rec_we, r_state == S_WB || r_state == S_NBWR, "page record written outside a write step")
    `SCPA_ASSERT_IMP(a_lnk_write_free, lnk_we, r_op == OP_FREE && r_state == S_SEQ, "slot link written outside a free")
endmodule
